// ----- rtl/rebd_pkg.sv -----
// ----------------------------------------------------------------------------
// rebd_pkg: shared definitions for the rotary encoder burst decoder
// Widths, stream packing, register indexes and direction codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rebd_pkg;

  // Timestamp and tally widths.
  localparam int TIME_BITS  = 48;
  localparam int TALLY_BITS = 8;

  // Configuration register widths.
  localparam int CFG_BITS      = 24;
  localparam int PPS_BITS      = 4;
  localparam int CFG_ADDR_BITS = 2;

  // Result fields.
  localparam int STEP_BITS  = 9;
  localparam int STEP_LIMIT = 255;
  localparam int MAG_BITS   = STEP_BITS - 1;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_BITS  = ((TIME_BITS + 2 + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((STEP_BITS + 1 + 7) / 8) * 8;

  localparam logic [TALLY_BITS-1:0] TALLY_MAX = {TALLY_BITS{1'b1}};

  // Common width for comparing the tally against small constants.
  localparam int WIDE_BITS = (TALLY_BITS > STEP_BITS) ? TALLY_BITS : STEP_BITS;

  // Iteration counter of the restoring divider.
  localparam int DIV_CNT_BITS = $clog2(TALLY_BITS);

  // Reset values of the configuration registers.
  localparam logic [CFG_BITS-1:0] MIN_STEP_RESET     = CFG_BITS'(20000);
  localparam logic [CFG_BITS-1:0] REVERSE_LOCK_RESET = CFG_BITS'(100000);
  localparam logic [CFG_BITS-1:0] BURST_IDLE_RESET   = CFG_BITS'(80000);
  localparam logic [PPS_BITS-1:0] PPS_RESET          = PPS_BITS'(2);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_MIN_STEP_TIME     = 2'd0,
    REG_REVERSE_LOCK_TIME = 2'd1,
    REG_BURST_IDLE_TIME   = 2'd2,
    REG_PULSES_PER_STEP   = 2'd3
  } cfg_reg_t;

  // Two-bit two's complement direction and sign codes.
  typedef logic [1:0] dir_t;
  localparam dir_t DIR_NONE = 2'b00;
  localparam dir_t DIR_POS  = 2'b01;
  localparam dir_t DIR_NEG  = 2'b11;

endpackage

`default_nettype wire

// ----- rtl/rotary_encoder_burst_decoder.sv -----
// A sample that emits no steps passes through S_GAP, S_MIN, S_LOCK, S_BURST and S_DONE;
// one that emits steps runs the divider in S_DIV between S_BURST and S_DONE as well.
// A new sample is taken only after the last one leaves S_DONE, as the single shared subtractor
// does the gap, the three threshold compares and each bit of the divide.
// Reset (rst, synchronous, active high) restores register defaults, clears the
// decoder state and drops the output valid.
// ----------------------------------------------------------------------------
// rotary_encoder_burst_decoder: debounced rotary encoder with burst step output
// Decodes falling clock edges into pulses, filters them by step time and a
// reversal lock, tallies them and emits whole steps once the knob goes idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_burst_decoder (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Configuration write port.
  input  wire logic                               cfg_we,
  input  wire logic [rebd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [rebd_pkg::CFG_BITS-1:0]      cfg_wdata,
  // Sample stream.
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // s_tdata fields from bit 0 up: clock_level, data_level, sample_time.
  input  wire logic [rebd_pkg::IN_DATA_BITS-1:0]  s_tdata,
  // Result stream.
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // m_tdata fields from bit 0 up: step_count, hold_flag.
  output logic [rebd_pkg::OUT_DATA_BITS-1:0]      m_tdata
);

  localparam int TB = rebd_pkg::TIME_BITS;
  localparam int NB = rebd_pkg::TALLY_BITS;
  localparam int PB = rebd_pkg::PPS_BITS;

  // One-hot sequencer. S_GAP to S_BURST each use the shared subtractor once; S_DIV uses it for each quotient bit.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,  // waiting for a sample
    S_GAP   = 7'b0000010,  // gap = now - last accepted pulse time
    S_MIN   = 7'b0000100,  // gap against minimum step time
    S_LOCK  = 7'b0001000,  // gap against reversal lock, then accept decision
    S_BURST = 7'b0010000,  // gap against burst idle time
    S_DIV   = 7'b0100000,  // one quotient bit per cycle
    S_DONE  = 7'b1000000   // result waits for the output register
  } state_t;

  state_t state;

  // Configuration registers.
  logic [rebd_pkg::CFG_BITS-1:0] min_step_time;
  logic [rebd_pkg::CFG_BITS-1:0] reverse_lock_time;
  logic [rebd_pkg::CFG_BITS-1:0] burst_idle_time;
  logic [PB-1:0]                 pulses_per_step;

  // Decoder state.
  logic                  previous_clock;
  rebd_pkg::dir_t        locked_direction;
  logic [TB-1:0]         last_accept_time;
  logic [NB-1:0]         pulse_tally;
  rebd_pkg::dir_t        run_sign;

  // Per-sample working registers.
  logic [TB-1:0]         now;
  rebd_pkg::dir_t        dir;
  logic [TB-1:0]         gap;
  logic                  ge_min;
  logic                  divided;
  logic                  hold;
  logic [NB-1:0]         div_src;
  logic [NB-1:0]         quot;
  logic [PB-1:0]         rem;
  logic [rebd_pkg::DIV_CNT_BITS-1:0] div_cnt;

  // Output register.
  logic [rebd_pkg::STEP_BITS-1:0] out_step;
  logic                           out_hold;

  // Shared subtractor: diff = a - b, borrow set when a < b.
  logic [TB-1:0] alu_a;
  logic [TB-1:0] alu_b;
  logic [TB:0]   alu_diff;
  logic          alu_borrow;

  // A zero pulses-per-step register acts as one.
  logic [PB-1:0] pps_eff;
  logic [PB:0]   div_shift;
  logic [PB-1:0] rem_new;
  logic          qbit;

  logic          in_fire;
  logic          accept;
  logic          tally_ge_pps;
  logic [rebd_pkg::WIDE_BITS-1:0] quot_wide;
  logic [rebd_pkg::MAG_BITS-1:0]  step_mag;
  logic [rebd_pkg::STEP_BITS-1:0] step_value;
  rebd_pkg::dir_t                 in_dir;

  assign pps_eff   = (pulses_per_step == '0) ? PB'(1) : pulses_per_step;
  assign div_shift = {rem, div_src[NB-1]};

  always_comb begin
    case (state)
      S_GAP: begin
        alu_a = now;
        alu_b = last_accept_time;
      end
      S_MIN: begin
        alu_a = gap;
        alu_b = TB'(min_step_time);
      end
      S_LOCK: begin
        alu_a = gap;
        alu_b = TB'(reverse_lock_time);
      end
      S_BURST: begin
        alu_a = gap;
        alu_b = TB'(burst_idle_time);
      end
      S_DIV: begin
        alu_a = TB'(div_shift);
        alu_b = TB'(pps_eff);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[TB];

  // Restoring divide step: subtract when the shifted remainder reaches the divisor.
  assign qbit    = ~alu_borrow;
  assign rem_new = qbit ? alu_diff[PB-1:0] : div_shift[PB-1:0];

  assign in_fire = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);

  // A falling clock edge is a pulse; the data line gives its direction.
  assign in_dir = (previous_clock && !s_tdata[0]) ?
                  (s_tdata[1] ? rebd_pkg::DIR_POS : rebd_pkg::DIR_NEG) : rebd_pkg::DIR_NONE;

  // Accept decision in S_LOCK, where the subtractor borrow means gap < lock time.
  // A reversal against the locked direction inside the lock window is rejected.
  assign accept = (dir != rebd_pkg::DIR_NONE) && ge_min &&
                  !((locked_direction != rebd_pkg::DIR_NONE) &&
                    (dir != locked_direction) && alu_borrow);

  assign tally_ge_pps = rebd_pkg::WIDE_BITS'(pulse_tally) >= rebd_pkg::WIDE_BITS'(pps_eff);

  // Whole steps saturate to the step limit and take the run's sign.
  assign quot_wide = rebd_pkg::WIDE_BITS'(quot);
  assign step_mag  = (quot_wide > rebd_pkg::WIDE_BITS'(rebd_pkg::STEP_LIMIT)) ?
                     rebd_pkg::MAG_BITS'(rebd_pkg::STEP_LIMIT) : quot_wide[rebd_pkg::MAG_BITS-1:0];

  always_comb begin
    if (!divided) begin
      step_value = '0;
    end else if (run_sign == rebd_pkg::DIR_NEG) begin
      step_value = -{1'b0, step_mag};
    end else if (run_sign == rebd_pkg::DIR_POS) begin
      step_value = {1'b0, step_mag};
    end else begin
      step_value = '0;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_step_time     <= rebd_pkg::MIN_STEP_RESET;
      reverse_lock_time <= rebd_pkg::REVERSE_LOCK_RESET;
      burst_idle_time   <= rebd_pkg::BURST_IDLE_RESET;
      pulses_per_step   <= rebd_pkg::PPS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        rebd_pkg::REG_MIN_STEP_TIME:     min_step_time     <= cfg_wdata;
        rebd_pkg::REG_REVERSE_LOCK_TIME: reverse_lock_time <= cfg_wdata;
        rebd_pkg::REG_BURST_IDLE_TIME:   burst_idle_time   <= cfg_wdata;
        rebd_pkg::REG_PULSES_PER_STEP:   pulses_per_step   <= cfg_wdata[PB-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      previous_clock   <= 1'b1;
      locked_direction <= rebd_pkg::DIR_NONE;
      last_accept_time <= '0;
      pulse_tally      <= '0;
      run_sign         <= rebd_pkg::DIR_NONE;
      m_tvalid         <= 1'b0;
    end else begin
      // The output register loads when it is empty or being drained; a result
      // taken with nothing new behind it leaves the register empty.
      if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            now            <= s_tdata[TB+1:2];
            dir            <= in_dir;
            previous_clock <= s_tdata[0];
            state          <= S_GAP;
          end
        end
        S_GAP: begin
          gap   <= alu_diff[TB-1:0];
          state <= S_MIN;
        end
        S_MIN: begin
          ge_min <= ~alu_borrow;
          state  <= S_LOCK;
        end
        S_LOCK: begin
          if (accept) begin
            locked_direction <= dir;
            last_accept_time <= now;
            // The idle check that follows sees a gap of zero.
            gap <= '0;
            if (dir != run_sign) begin
              run_sign    <= dir;
              pulse_tally <= NB'(1);
            end else if (pulse_tally != rebd_pkg::TALLY_MAX) begin
              pulse_tally <= pulse_tally + NB'(1);
            end
          end
          state <= S_BURST;
        end
        S_BURST: begin
          if (tally_ge_pps && !alu_borrow) begin
            // Idle long enough with at least one whole step held.
            div_src <= pulse_tally;
            rem     <= '0;
            div_cnt <= rebd_pkg::DIV_CNT_BITS'(NB - 1);
            divided <= 1'b1;
            hold    <= 1'b0;
            state   <= S_DIV;
          end else begin
            divided <= 1'b0;
            hold    <= (pulse_tally != '0) && alu_borrow;
            state   <= S_DONE;
          end
        end
        S_DIV: begin
          div_src <= {div_src[NB-2:0], 1'b0};
          quot    <= {quot[NB-2:0], qbit};
          rem     <= rem_new;
          div_cnt <= div_cnt - rebd_pkg::DIV_CNT_BITS'(1);
          if (div_cnt == '0) begin
            pulse_tally      <= NB'(rem_new);
            locked_direction <= rebd_pkg::DIR_NONE;
            state            <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            out_step <= step_value;
            out_hold <= hold;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = rebd_pkg::OUT_DATA_BITS'({out_hold, out_step});

endmodule

`default_nettype wire

// ----- rtl/rebd_checker.sv -----
// ----------------------------------------------------------------------------
// rebd_checker: port-level assertions for the rotary encoder burst decoder
// Watches the stream handshakes and the result fields over time.
// ----------------------------------------------------------------------------
`default_nettype none

module rebd_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_tvalid,
  input wire logic                               s_tready,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [rebd_pkg::OUT_DATA_BITS-1:0] m_tdata
);

  localparam int SB = rebd_pkg::STEP_BITS;

  logic [SB-1:0] step;
  logic          hold;

  assign step = m_tdata[SB-1:0];
  assign hold = m_tdata[SB];

  // The block works on one sample at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("sample accepted while the previous one is still in work");

  // A stalled result stays offered.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped while stalled");

  // Nothing is offered right after reset.
  a_reset_clears_valid: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A sample that emits steps clears the hold flag, so hold and steps never show together.
  a_hold_excludes_steps: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(hold && (step != '0)))
    else $error("hold flag set together with emitted steps");

  // Saturation keeps the step count inside plus or minus the limit.
  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (step != {1'b1, {(SB-1){1'b0}}}))
    else $error("step count outside the saturation range");

endmodule

bind rotary_encoder_burst_decoder rebd_checker u_rebd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
